[rtl/core/hdp_pkg.sv]
// ----------------------------------------------------------------------------
// HTTP request head parser package
// Shared types, codes and constants of the front, back and output queue.
// ----------------------------------------------------------------------------
package hdp_pkg;

    localparam int COUNT_W = 12;
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;

    localparam logic [COUNT_W-1:0] METHOD_LIMIT_RST = 12'd15;
    localparam logic [COUNT_W-1:0] URI_LIMIT_RST    = 12'd1023;
    localparam logic [COUNT_W-1:0] NAME_LIMIT_RST   = 12'd63;
    localparam logic [COUNT_W-1:0] VALUE_LIMIT_RST  = 12'd1023;

    typedef enum logic [1:0] {
        REG_METHOD_LIMIT = 2'd0,
        REG_URI_LIMIT    = 2'd1,
        REG_NAME_LIMIT   = 2'd2,
        REG_VALUE_LIMIT  = 2'd3
    } reg_index_t;

    typedef enum logic [2:0] {
        PH_METHOD  = 3'd0,
        PH_URI     = 3'd1,
        PH_VERSION = 3'd2,
        PH_NAME    = 3'd3,
        PH_VALUE   = 3'd4,
        PH_ENDING  = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        EV_DATA  = 2'd0,
        EV_END   = 2'd1,
        EV_DONE  = 2'd2,
        EV_ERROR = 2'd3
    } event_t;

    typedef enum logic [1:0] {
        FK_METHOD = 2'd0,
        FK_URI    = 2'd1,
        FK_NAME   = 2'd2,
        FK_VALUE  = 2'd3
    } field_kind_t;

    typedef enum logic [2:0] {
        ERR_METHOD_LONG = 3'd0,
        ERR_URI_LONG    = 3'd1,
        ERR_NAME_LONG   = 3'd2,
        ERR_EMPTY_NAME  = 3'd3,
        ERR_LF_VERSION  = 3'd4,
        ERR_LF_HEADER   = 3'd5,
        ERR_BAD_ENDING  = 3'd6
    } error_kind_t;

    typedef struct packed {
        logic [7:0] data;
        logic       is_sp;
        logic       is_cr;
        logic       is_lf;
        logic       is_colon;
    } byte_item_t;

    typedef struct packed {
        event_t             ev;
        field_kind_t        kind;
        logic [7:0]         data;
        logic [COUNT_W-1:0] length;
        error_kind_t        err;
    } result_t;

    typedef struct packed {
        logic [7:0]         method_limit;
        logic [COUNT_W-1:0] uri_limit;
        logic [COUNT_W-1:0] name_limit;
        logic [COUNT_W-1:0] value_limit;
    } limits_t;

endpackage

[rtl/core/hdp_front.sv]
// ----------------------------------------------------------------------------
// HTTP request head parser front
// Accepts raw bytes, tags each with its delimiter class and queues it.
// ----------------------------------------------------------------------------
module hdp_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic [7:0]          in_byte,
    output logic                full,
    output logic                item_valid,
    output hdp_pkg::byte_item_t item,
    input  logic                item_take
);

    hdp_pkg::byte_item_t               mem_reg [hdp_pkg::QDEPTH];
    hdp_pkg::byte_item_t               new_item;
    logic [hdp_pkg::QPTR_W-1:0]        wptr_reg;
    logic [hdp_pkg::QPTR_W-1:0]        wptr_next;
    logic [hdp_pkg::QPTR_W-1:0]        rptr_reg;
    logic [hdp_pkg::QPTR_W-1:0]        rptr_next;
    logic [hdp_pkg::QCNT_W-1:0]        count_reg;
    logic [hdp_pkg::QCNT_W-1:0]        count_next;
    logic                              wr_en;
    logic                              rd_en;

    always_comb
    begin
        new_item.data     = in_byte;
        new_item.is_sp    = (in_byte == hdp_pkg::CH_SP);
        new_item.is_cr    = (in_byte == hdp_pkg::CH_CR);
        new_item.is_lf    = (in_byte == hdp_pkg::CH_LF);
        new_item.is_colon = (in_byte == hdp_pkg::CH_COLON);
    end

    assign full       = (count_reg == hdp_pkg::QCNT_W'(hdp_pkg::QDEPTH));
    assign item_valid = (count_reg != '0);
    assign item       = mem_reg[rptr_reg];
    assign wr_en      = push && !full;
    assign rd_en      = item_take && item_valid;

    always_comb
    begin
        wptr_next  = wr_en ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next  = rd_en ? rptr_reg + 1'b1 : rptr_reg;
        count_next = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wptr_reg] <= new_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

endmodule

[rtl/core/hdp_back.sv]
// ----------------------------------------------------------------------------
// HTTP request head parser back
// Runs the parse state machine on classified bytes and forms result beats.
// ----------------------------------------------------------------------------
module hdp_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  hdp_pkg::limits_t    limits,
    input  logic                item_valid,
    input  hdp_pkg::byte_item_t item,
    output logic                item_take,
    input  logic                res_full,
    output logic                res_push,
    output hdp_pkg::result_t    res
);

    hdp_pkg::phase_t                 phase_reg;
    hdp_pkg::phase_t                 phase_next;
    logic [hdp_pkg::COUNT_W-1:0]     count_reg;
    logic [hdp_pkg::COUNT_W-1:0]     count_next;
    logic                            prev_cr_reg;
    logic                            prev_cr_next;
    logic                            name_seen_reg;
    logic                            name_seen_next;
    logic [hdp_pkg::COUNT_W-1:0]     strict_limit;
    logic                            strict_room;
    logic                            value_room;
    logic                            restart;
    logic                            res_valid;

    assign item_take = item_valid && !res_full;
    assign res_push  = item_take && res_valid;

    always_comb
    begin
        case (phase_reg)
            hdp_pkg::PH_METHOD:
            begin
                strict_limit = {4'd0, limits.method_limit};
            end
            hdp_pkg::PH_URI:
            begin
                strict_limit = limits.uri_limit;
            end
            default:
            begin
                strict_limit = limits.name_limit;
            end
        endcase
    end

    assign strict_room = (count_reg < strict_limit);
    assign value_room  = (count_reg < limits.value_limit);

    always_comb
    begin
        phase_next     = phase_reg;
        count_next     = count_reg;
        name_seen_next = name_seen_reg;
        restart        = 1'b0;
        case (phase_reg)
            hdp_pkg::PH_METHOD, hdp_pkg::PH_URI:
            begin
                if (!item.is_sp)
                begin
                    if (strict_room)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    else
                    begin
                        restart = 1'b1;
                    end
                end
                else
                begin
                    count_next = '0;
                    phase_next = (phase_reg == hdp_pkg::PH_METHOD) ?
                                 hdp_pkg::PH_URI : hdp_pkg::PH_VERSION;
                end
            end
            hdp_pkg::PH_VERSION:
            begin
                if (item.is_lf)
                begin
                    if (!prev_cr_reg)
                    begin
                        restart = 1'b1;
                    end
                    else
                    begin
                        count_next     = '0;
                        name_seen_next = 1'b0;
                        phase_next     = hdp_pkg::PH_NAME;
                    end
                end
            end
            hdp_pkg::PH_NAME:
            begin
                if (item.is_cr)
                begin
                    phase_next = hdp_pkg::PH_ENDING;
                end
                else if (!item.is_colon)
                begin
                    name_seen_next = 1'b1;
                    if (strict_room)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    else
                    begin
                        restart = 1'b1;
                    end
                end
                else if (!name_seen_reg)
                begin
                    restart = 1'b1;
                end
                else
                begin
                    count_next = '0;
                    phase_next = hdp_pkg::PH_VALUE;
                end
            end
            hdp_pkg::PH_VALUE:
            begin
                if (item.is_cr)
                begin
                    count_next = '0;
                end
                else if (item.is_lf)
                begin
                    if (!prev_cr_reg)
                    begin
                        restart = 1'b1;
                    end
                    else
                    begin
                        count_next     = '0;
                        name_seen_next = 1'b0;
                        phase_next     = hdp_pkg::PH_NAME;
                    end
                end
                else if (!(count_reg == '0 && item.is_sp) && value_room)
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            default:
            begin
                restart = 1'b1;
            end
        endcase
        if (restart)
        begin
            phase_next     = hdp_pkg::PH_METHOD;
            count_next     = '0;
            name_seen_next = 1'b0;
        end
        prev_cr_next = restart ? 1'b0 : item.is_cr;
    end

    always_comb
    begin
        res_valid  = 1'b0;
        res.ev     = hdp_pkg::EV_DATA;
        res.kind   = hdp_pkg::FK_METHOD;
        res.data   = '0;
        res.length = '0;
        res.err    = hdp_pkg::ERR_METHOD_LONG;
        case (phase_reg)
            hdp_pkg::PH_METHOD, hdp_pkg::PH_URI:
            begin
                res_valid = 1'b1;
                if (!item.is_sp && strict_room)
                begin
                    res.kind = (phase_reg == hdp_pkg::PH_METHOD) ?
                               hdp_pkg::FK_METHOD : hdp_pkg::FK_URI;
                    res.data = item.data;
                end
                else if (!item.is_sp)
                begin
                    res.ev  = hdp_pkg::EV_ERROR;
                    res.err = (phase_reg == hdp_pkg::PH_METHOD) ?
                              hdp_pkg::ERR_METHOD_LONG : hdp_pkg::ERR_URI_LONG;
                end
                else
                begin
                    res.ev     = hdp_pkg::EV_END;
                    res.kind   = (phase_reg == hdp_pkg::PH_METHOD) ?
                                 hdp_pkg::FK_METHOD : hdp_pkg::FK_URI;
                    res.length = count_reg;
                end
            end
            hdp_pkg::PH_VERSION:
            begin
                if (item.is_lf && !prev_cr_reg)
                begin
                    res_valid = 1'b1;
                    res.ev    = hdp_pkg::EV_ERROR;
                    res.err   = hdp_pkg::ERR_LF_VERSION;
                end
            end
            hdp_pkg::PH_NAME:
            begin
                if (!item.is_cr)
                begin
                    res_valid = 1'b1;
                    if (!item.is_colon && strict_room)
                    begin
                        res.kind = hdp_pkg::FK_NAME;
                        res.data = item.data;
                    end
                    else if (!item.is_colon)
                    begin
                        res.ev  = hdp_pkg::EV_ERROR;
                        res.err = hdp_pkg::ERR_NAME_LONG;
                    end
                    else if (!name_seen_reg)
                    begin
                        res.ev  = hdp_pkg::EV_ERROR;
                        res.err = hdp_pkg::ERR_EMPTY_NAME;
                    end
                    else
                    begin
                        res.ev     = hdp_pkg::EV_END;
                        res.kind   = hdp_pkg::FK_NAME;
                        res.length = count_reg;
                    end
                end
            end
            hdp_pkg::PH_VALUE:
            begin
                if (item.is_cr)
                begin
                    res_valid  = 1'b1;
                    res.ev     = hdp_pkg::EV_END;
                    res.kind   = hdp_pkg::FK_VALUE;
                    res.length = count_reg;
                end
                else if (item.is_lf)
                begin
                    if (!prev_cr_reg)
                    begin
                        res_valid = 1'b1;
                        res.ev    = hdp_pkg::EV_ERROR;
                        res.err   = hdp_pkg::ERR_LF_HEADER;
                    end
                end
                else if (!(count_reg == '0 && item.is_sp) && value_room)
                begin
                    res_valid = 1'b1;
                    res.kind  = hdp_pkg::FK_VALUE;
                    res.data  = item.data;
                end
            end
            hdp_pkg::PH_ENDING:
            begin
                res_valid = 1'b1;
                if (item.is_lf && prev_cr_reg)
                begin
                    res.ev = hdp_pkg::EV_DONE;
                end
                else
                begin
                    res.ev  = hdp_pkg::EV_ERROR;
                    res.err = hdp_pkg::ERR_BAD_ENDING;
                end
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= hdp_pkg::PH_METHOD;
            count_reg     <= '0;
            prev_cr_reg   <= 1'b0;
            name_seen_reg <= 1'b0;
        end
        else if (item_take)
        begin
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            prev_cr_reg   <= prev_cr_next;
            name_seen_reg <= name_seen_next;
        end
    end

endmodule

[rtl/core/hdp_out_queue.sv]
// ----------------------------------------------------------------------------
// HTTP request head parser output queue
// Holds result beats until the consumer pops them.
// ----------------------------------------------------------------------------
module hdp_out_queue
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             res_push,
    input  hdp_pkg::result_t res,
    output logic             res_full,
    input  logic             pop,
    output logic             empty,
    output hdp_pkg::result_t head
);

    hdp_pkg::result_t                  mem_reg [hdp_pkg::QDEPTH];
    logic [hdp_pkg::QPTR_W-1:0]        wptr_reg;
    logic [hdp_pkg::QPTR_W-1:0]        wptr_next;
    logic [hdp_pkg::QPTR_W-1:0]        rptr_reg;
    logic [hdp_pkg::QPTR_W-1:0]        rptr_next;
    logic [hdp_pkg::QCNT_W-1:0]        count_reg;
    logic [hdp_pkg::QCNT_W-1:0]        count_next;
    logic                              wr_en;
    logic                              rd_en;

    assign res_full = (count_reg == hdp_pkg::QCNT_W'(hdp_pkg::QDEPTH));
    assign empty    = (count_reg == '0);
    assign head     = mem_reg[rptr_reg];
    assign wr_en    = res_push && !res_full;
    assign rd_en    = pop && !empty;

    always_comb
    begin
        wptr_next  = wr_en ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next  = rd_en ? rptr_reg + 1'b1 : rptr_reg;
        count_next = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wptr_reg] <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

endmodule

[rtl/core/http_request_head_parser.sv]
// ----------------------------------------------------------------------------
// HTTP request head parser
// Streams method, URI, header names and values out of a raw request head.
//
//   channel   direction  handshake            payload
//   input     in         push / full          in_byte
//   result    out        empty / pop          event_res, field_kind, out_byte,
//                                             field_length, error_kind
//   config    in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One byte per cycle sustained while the result queue has room; a result is
// written into the output queue at the same edge that takes its byte.
// The back's parse state machine takes one queued byte each unstalled cycle.
// Reset clears the queues and parse state; limits return to their defaults.
// A full result queue holds the back; the input queue then fills and raises
// full. Configuration is always ready.
// ----------------------------------------------------------------------------
module http_request_head_parser
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic [7:0]  in_byte,
    output logic        full,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  event_res,
    output logic [1:0]  field_kind,
    output logic [7:0]  out_byte,
    output logic [11:0] field_length,
    output logic [2:0]  error_kind,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_data
);

    hdp_pkg::limits_t    limits_reg;
    hdp_pkg::limits_t    limits_next;
    hdp_pkg::byte_item_t item;
    hdp_pkg::result_t    res;
    hdp_pkg::result_t    head;
    logic                item_valid;
    logic                item_take;
    logic                res_full;
    logic                res_push;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        limits_next = limits_reg;
        if (cfg_valid)
        begin
            case (hdp_pkg::reg_index_t'(cfg_index))
                hdp_pkg::REG_METHOD_LIMIT: limits_next.method_limit = cfg_data[7:0];
                hdp_pkg::REG_URI_LIMIT:    limits_next.uri_limit    = cfg_data;
                hdp_pkg::REG_NAME_LIMIT:   limits_next.name_limit   = cfg_data;
                hdp_pkg::REG_VALUE_LIMIT:  limits_next.value_limit  = cfg_data;
                default:                   limits_next = limits_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limits_reg.method_limit <= hdp_pkg::METHOD_LIMIT_RST[7:0];
            limits_reg.uri_limit    <= hdp_pkg::URI_LIMIT_RST;
            limits_reg.name_limit   <= hdp_pkg::NAME_LIMIT_RST;
            limits_reg.value_limit  <= hdp_pkg::VALUE_LIMIT_RST;
        end
        else
        begin
            limits_reg <= limits_next;
        end
    end

    hdp_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .in_byte    (in_byte),
        .full       (full),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    hdp_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .limits     (limits_reg),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .res_full   (res_full),
        .res_push   (res_push),
        .res        (res)
    );

    hdp_out_queue u_out_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (res_push),
        .res      (res),
        .res_full (res_full),
        .pop      (pop),
        .empty    (empty),
        .head     (head)
    );

    assign event_res    = head.ev;
    assign field_kind   = head.kind;
    assign out_byte     = head.data;
    assign field_length = head.length;
    assign error_kind   = head.err;

endmodule
